@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

@@ rtl/atc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package atc_pkg;
	localparam logic [2:0] CMD_IDENTITY  = 3'd0;
	localparam logic [2:0] CMD_TRANSLATE = 3'd1;
	localparam logic [2:0] CMD_SCALE     = 3'd2;
	localparam logic [2:0] CMD_ROTATE    = 3'd3;
	localparam logic [2:0] CMD_READ      = 3'd4;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] op_x;
		logic signed [31:0] op_y;
		logic signed [31:0] op_z;
		logic signed [31:0] op_w;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic [1:0]         column_index;
		logic signed [31:0] element_value;
		logic               last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic       load_ops;   // capture operands
		logic       set_ident;  // matrix to identity
		logic       rot_prod;   // rotation product step
		logic [3:0] rot_sel;    // which quaternion product
		logic       rot_build;  // assemble rotation matrix
		logic       mac_clr;    // clear accumulator
		logic       mac_step;   // accumulate one product
		logic [3:0] elem;       // element i*4+j
		logic [1:0] k;          // inner index
		logic       mac_store;  // saturate into scratch
		logic       commit;     // copy scratch to matrix
	} ctrl_t;
endpackage
`default_nettype wire

@@ rtl/affine_transform_composer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Keeps a 4x4 Q16.16 transform matrix, reset to identity, and composes
// translate, scale and quaternion rotate commands on its left through one
// shared 32x32 multiplier: each element is accumulated product by product
// over the inner index and then stored; rotate first forms the quaternion
// products and builds its matrix. Identity is set directly. A read emits
// 16 items, each held until the sink takes it. One command is taken at a time.
`include "assert_macros.svh"
module affine_transform_composer #(
	parameter int FRAC_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  atc_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  wire                 out_ready,
	output atc_pkg::out_item_t  out_item
);
	atc_pkg::ctrl_t     ctrl;
	logic [3:0]         rd_elem, out_elem;
	logic signed [31:0] rd_value;

	atc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(in_item.command), .ctrl(ctrl), .rd_elem(rd_elem),
		.out_valid(out_valid), .out_ready(out_ready), .out_elem(out_elem)
	);

	atc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .in_item(in_item), .ctrl(ctrl), .rd_elem(rd_elem),
		.rd_value(rd_value), .arst_n(arst_n)
	);

	assign out_item.row_index     = out_elem[3:2];
	assign out_item.column_index  = out_elem[1:0];
	assign out_item.element_value = rd_value;
	assign out_item.last          = (out_elem == 4'd15);

	`CHK_IMPL(a_no_in_while_out, clk, arst_n, out_valid, !in_ready)
	`CHK_NEXT(a_commit_idle, clk, arst_n, ctrl.commit, in_ready)
	`CHK_IMPL(a_store_no_step, clk, arst_n, ctrl.mac_store, !ctrl.mac_step)
endmodule
`default_nettype wire

@@ rtl/atc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module atc_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  atc_pkg::in_item_t  in_item,
	input  atc_pkg::ctrl_t     ctrl,
	input  wire  [3:0]         rd_elem,
	output logic signed [31:0] rd_value,
	input  wire                arst_n
);
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] MAXV = 64'sd2147483647;
	localparam logic signed [63:0] MINV = -64'sd2147483648;

	logic signed [31:0] t_q [16];
	logic signed [31:0] m_q [16];
	logic signed [31:0] n_q [16];
	logic signed [31:0] x_q, y_q, z_q, w_q;
	logic signed [63:0] p_q [9];
	logic signed [63:0] acc_q;

	// shared multiplier operand selection
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [63:0] prod_t;
	always_comb begin
		ma = m_q[{ctrl.elem[3:2], ctrl.k}];
		mb = t_q[{ctrl.k, ctrl.elem[1:0]}];
		if (ctrl.rot_prod) begin
			case (ctrl.rot_sel)
				4'd0: begin ma = x_q; mb = x_q; end
				4'd1: begin ma = y_q; mb = y_q; end
				4'd2: begin ma = z_q; mb = z_q; end
				4'd3: begin ma = x_q; mb = y_q; end
				4'd4: begin ma = x_q; mb = z_q; end
				4'd5: begin ma = y_q; mb = z_q; end
				4'd6: begin ma = w_q; mb = x_q; end
				4'd7: begin ma = w_q; mb = y_q; end
				default: begin ma = w_q; mb = z_q; end
			endcase
		end
		prod   = ma * mb;
		// full-width truncated product, no wrap before the sum
		prod_t = prod >>> FRAC_BITS;
	end

	function automatic logic signed [31:0] sat(input logic signed [63:0] v);
		if (v > MAXV) return 32'sh7fffffff;
		if (v < MINV) return 32'sh80000000;
		return 32'(v);
	endfunction

	// doubled truncated products
	logic signed [63:0] xx, yy, zz, xy, xz, yz, wx, wy, wz, one_e;
	always_comb begin
		xx = p_q[0]; yy = p_q[1]; zz = p_q[2];
		xy = p_q[3]; xz = p_q[4]; yz = p_q[5];
		wx = p_q[6]; wy = p_q[7]; wz = p_q[8];
		one_e = 64'(ONE);
	end

	// operand, build, mac and scratch registers
	always_ff @(posedge clk) begin
		if (ctrl.load_ops) begin
			x_q <= in_item.op_x; y_q <= in_item.op_y;
			z_q <= in_item.op_z; w_q <= in_item.op_w;
			for (int i = 0; i < 16; i++)
				m_q[i] <= (i % 5 == 0) ? ONE : 32'sd0;
			if (in_item.command == atc_pkg::CMD_TRANSLATE) begin
				m_q[12] <= in_item.op_x; m_q[13] <= in_item.op_y;
				m_q[14] <= in_item.op_z;
			end else if (in_item.command == atc_pkg::CMD_SCALE) begin
				m_q[0] <= in_item.op_x; m_q[5] <= in_item.op_y;
				m_q[10] <= in_item.op_z;
			end
		end
		if (ctrl.rot_prod)
			p_q[ctrl.rot_sel] <= prod_t <<< 1;
		if (ctrl.rot_build) begin
			m_q[0]  <= sat(one_e - yy - zz);
			m_q[4]  <= sat(xy - wz);
			m_q[8]  <= sat(xz + wy);
			m_q[1]  <= sat(xy + wz);
			m_q[5]  <= sat(one_e - xx - zz);
			m_q[9]  <= sat(yz - wx);
			m_q[2]  <= sat(xz - wy);
			m_q[6]  <= sat(yz + wx);
			m_q[10] <= sat(one_e - xx - yy);
		end
		if (ctrl.mac_clr)
			acc_q <= '0;
		else if (ctrl.mac_step)
			acc_q <= acc_q + prod_t;
		if (ctrl.mac_store)
			n_q[ctrl.elem] <= sat(acc_q);
		rd_value <= t_q[rd_elem];
	end

	// current matrix, identity out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				t_q[i] <= (i % 5 == 0) ? ONE : 32'sd0;
		end else if (ctrl.set_ident) begin
			for (int i = 0; i < 16; i++)
				t_q[i] <= (i % 5 == 0) ? ONE : 32'sd0;
		end else if (ctrl.commit) begin
			t_q <= n_q;
		end
	end
endmodule
`default_nettype wire

@@ rtl/atc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module atc_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [2:0]         command,
	output atc_pkg::ctrl_t     ctrl,
	output logic [3:0]         rd_elem,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [3:0]         out_elem
);
	typedef enum logic [2:0] {S_IDLE, S_ROT, S_BUILD, S_MAC, S_STORE, S_COMMIT,
		S_RD, S_OUT} state_t;
	state_t     state_q;
	logic [3:0] cnt_q, elem_q;
	logic [1:0] k_q;

	assign in_ready = (state_q == S_IDLE);
	assign rd_elem  = elem_q;
	assign out_elem = elem_q;
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		ctrl = '0;
		ctrl.load_ops  = in_valid && in_ready;
		ctrl.set_ident = in_valid && in_ready && command == atc_pkg::CMD_IDENTITY;
		ctrl.rot_prod  = (state_q == S_ROT);
		ctrl.rot_sel   = cnt_q;
		ctrl.rot_build = (state_q == S_BUILD);
		ctrl.mac_clr   = (state_q == S_BUILD) || (state_q == S_STORE) ||
			(ctrl.load_ops && command != atc_pkg::CMD_ROTATE);
		ctrl.mac_step  = (state_q == S_MAC);
		ctrl.elem      = elem_q;
		ctrl.k         = k_q;
		ctrl.mac_store = (state_q == S_STORE);
		ctrl.commit    = (state_q == S_COMMIT);
	end

	// sequencer state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; cnt_q <= '0; elem_q <= '0; k_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					cnt_q <= '0; elem_q <= '0; k_q <= '0;
					case (command)
						atc_pkg::CMD_TRANSLATE, atc_pkg::CMD_SCALE: state_q <= S_MAC;
						atc_pkg::CMD_ROTATE: state_q <= S_ROT;
						atc_pkg::CMD_READ: state_q <= S_RD;
						default: state_q <= S_IDLE;
					endcase
				end
				S_ROT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd8) state_q <= S_BUILD;
				end
				S_BUILD: state_q <= S_MAC;
				S_MAC: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) state_q <= S_STORE;
				end
				S_STORE: begin
					elem_q <= elem_q + 4'd1;
					state_q <= (elem_q == 4'd15) ? S_COMMIT : S_MAC;
				end
				S_COMMIT: state_q <= S_IDLE;
				S_RD: state_q <= S_OUT;
				S_OUT: if (out_ready) begin
					elem_q <= elem_q + 4'd1;
					state_q <= (elem_q == 4'd15) ? S_IDLE : S_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	localparam int FRAC = 16;
	localparam logic signed [31:0] ONE_FX = 32'sh0001_0000;
	localparam logic signed [31:0] MAX_FX = 32'sh7fff_ffff;
	localparam logic signed [31:0] MIN_FX = 32'sh8000_0000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	atc_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready;
	atc_pkg::out_item_t out_item;

	affine_transform_composer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	// predictor state: current matrix, row-major
	logic signed [31:0] cur_matrix [16];
	atc_pkg::in_item_t pending_cmds [$];
	atc_pkg::out_item_t expected_elems [$];
	int error_count = 0;
	bit stimulus_done = 0;
	bit hold_sink = 0;
	bit calm_phase = 0;

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		error_count++;
	endtask

	function automatic logic signed [63:0] fx_product(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p >>> FRAC;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return MAX_FX;
		if (v < -64'sd2147483648)
			return MIN_FX;
		return v[31:0];
	endfunction

	function automatic void identity_into(output logic signed [31:0] m [16]);
		for (int i = 0; i < 16; i++)
			m[i] = (i % 5 == 0) ? ONE_FX : 32'sd0;
	endfunction

	// new matrix = m times current matrix
	function automatic void compose_left(input logic signed [31:0] m [16]);
		logic signed [31:0] tmp [16];
		logic signed [63:0] acc;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				acc = '0;
				for (int k = 0; k < 4; k++)
					acc += fx_product(m[i*4+k], cur_matrix[k*4+j]);
				tmp[i*4+j] = clamp32(acc);
			end
		cur_matrix = tmp;
	endfunction

	function automatic void predict_command(input atc_pkg::in_item_t c);
		logic signed [31:0] m [16];
		logic signed [63:0] x, y, z, w, xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
		atc_pkg::out_item_t r;
		x = c.op_x;
		y = c.op_y;
		z = c.op_z;
		w = c.op_w;
		one = 64'sd65536;
		identity_into(m);
		case (c.command)
			atc_pkg::CMD_IDENTITY: begin
				identity_into(cur_matrix);
			end
			atc_pkg::CMD_TRANSLATE: begin
				m[12] = c.op_x;
				m[13] = c.op_y;
				m[14] = c.op_z;
				compose_left(m);
			end
			atc_pkg::CMD_SCALE: begin
				m[0] = c.op_x;
				m[5] = c.op_y;
				m[10] = c.op_z;
				compose_left(m);
			end
			atc_pkg::CMD_ROTATE: begin
				xx = 2 * fx_product(x, x);
				yy = 2 * fx_product(y, y);
				zz = 2 * fx_product(z, z);
				xy = 2 * fx_product(x, y);
				xz = 2 * fx_product(x, z);
				yz = 2 * fx_product(y, z);
				wx = 2 * fx_product(w, x);
				wy = 2 * fx_product(w, y);
				wz = 2 * fx_product(w, z);
				m[0] = clamp32(one - yy - zz);
				m[4] = clamp32(xy - wz);
				m[8] = clamp32(xz + wy);
				m[1] = clamp32(xy + wz);
				m[5] = clamp32(one - xx - zz);
				m[9] = clamp32(yz - wx);
				m[2] = clamp32(xz - wy);
				m[6] = clamp32(yz + wx);
				m[10] = clamp32(one - xx - yy);
				compose_left(m);
			end
			atc_pkg::CMD_READ: begin
				for (int i = 0; i < 16; i++) begin
					r.row_index = 2'(i / 4);
					r.column_index = 2'(i % 4);
					r.element_value = cur_matrix[i];
					r.last = (i == 15);
					expected_elems.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return MAX_FX;
			1: return MIN_FX;
			2: return $urandom;
			3: return ONE_FX;
			4: return -ONE_FX;
			default: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
		endcase
	endfunction

	// unit quaternion-ish operands, Q16.16 in [-1, 1]
	function automatic logic signed [31:0] rand_unit();
		return $signed($urandom_range(0, 32'h0002_0000)) - ONE_FX;
	endfunction

	function automatic atc_pkg::in_item_t make_cmd(input logic [2:0] c,
			input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z, input logic signed [31:0] w);
		atc_pkg::in_item_t it;
		it.command = c;
		it.op_x = x;
		it.op_y = y;
		it.op_z = z;
		it.op_w = w;
		return it;
	endfunction

	// stimulus: directed then random
	initial begin
		int sel;
		atc_pkg::in_item_t it;
		identity_into(cur_matrix);
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_READ, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_TRANSLATE, ONE_FX, -ONE_FX,
			32'sh0003_8000, MAX_FX));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_READ, MAX_FX, MIN_FX, 0, 0));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_SCALE, 32'sh0002_0000, 32'sh0000_8000,
			-ONE_FX, 0));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_ROTATE, 0, 0, 32'sh0000_b505,
			32'sh0000_b505));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_READ, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_TRANSLATE, MAX_FX, MAX_FX, MAX_FX, 0));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_SCALE, MAX_FX, MIN_FX, MAX_FX, 0));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_READ, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_ROTATE, MAX_FX, MIN_FX, MAX_FX, MIN_FX));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_READ, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(3'd5, MAX_FX, 0, 0, 0));
		pending_cmds.push_back(make_cmd(3'd6, MIN_FX, 0, 0, 0));
		pending_cmds.push_back(make_cmd(3'd7, -1, -1, -1, -1));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_READ, -1, -1, -1, -1));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_IDENTITY, -1, -1, -1, -1));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_READ, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_SCALE, MIN_FX, MIN_FX, MIN_FX, -1));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_ROTATE, -1, -1, -1, -1));
		pending_cmds.push_back(make_cmd(atc_pkg::CMD_READ, 0, 0, 0, 0));
		for (int n = 0; n < 300; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 8)
				it = make_cmd(atc_pkg::CMD_IDENTITY, $urandom, $urandom, $urandom,
					$urandom);
			else if (sel < 28)
				it = make_cmd(atc_pkg::CMD_TRANSLATE, rand_operand(), rand_operand(),
					rand_operand(), $urandom);
			else if (sel < 45)
				it = make_cmd(atc_pkg::CMD_SCALE, rand_operand(), rand_operand(),
					rand_operand(), $urandom);
			else if (sel < 62)
				it = (sel < 58) ? make_cmd(atc_pkg::CMD_ROTATE, rand_unit(), rand_unit(),
					rand_unit(), rand_unit()) : make_cmd(atc_pkg::CMD_ROTATE,
					rand_operand(), rand_operand(), rand_operand(), rand_operand());
			else if (sel < 95)
				it = make_cmd(atc_pkg::CMD_READ, $urandom, $urandom, $urandom, $urandom);
			else
				it = make_cmd(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
			pending_cmds.push_back(it);
		end
	end

	// reset
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	initial begin
		in_valid = 1'b0;
		in_item = '0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_command(in_item);
				void'(pending_cmds.pop_front());
			end
			if (!(in_valid && !in_ready)) begin
				if (pending_cmds.size() > ((in_valid && in_ready) ? 1 : 0)
						&& (calm_phase || $urandom_range(0, 99) >= 36)) begin
					in_valid <= 1'b1;
					in_item <= pending_cmds[(in_valid && in_ready) ? 1 : 0];
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (pending_cmds.size() == 0)
				stimulus_done = 1;
		end
	end

	// monitor and sink
	initial out_ready = 1'b0;

	always @(posedge clk) begin
		atc_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_elems.size() == 0) begin
					report_mismatch("unexpected item", 64'(out_item), 64'd0);
				end else begin
					want = expected_elems.pop_front();
					if (out_item.row_index !== want.row_index)
						report_mismatch("row_index", 64'(out_item.row_index),
							64'(want.row_index));
					if (out_item.column_index !== want.column_index)
						report_mismatch("column_index", 64'(out_item.column_index),
							64'(want.column_index));
					if (out_item.element_value !== want.element_value)
						report_mismatch("element_value", 64'(out_item.element_value),
							64'(want.element_value));
					if (out_item.last !== want.last)
						report_mismatch("last", 64'(out_item.last), 64'(want.last));
				end
			end
			out_ready <= !hold_sink && (calm_phase || $urandom_range(0, 99) >= 36);
		end
	end

	// long sink hold-off with commands still offered, then a calm stretch
	initial begin
		wait (arst_n);
		wait (expected_elems.size() > 0);
		hold_sink = 1;
		repeat (600) @(posedge clk);
		hold_sink = 0;
		repeat (2000) @(posedge clk);
		calm_phase = 1;
		repeat (6000) @(posedge clk);
		calm_phase = 0;
	end

	// end of run
	initial begin
		wait (stimulus_done);
		wait (expected_elems.size() == 0);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end
endmodule

@@ affine_transform_composer.f @@
+incdir+rtl
rtl/atc_pkg.sv
rtl/atc_datapath.sv
rtl/atc_ctrl.sv
rtl/affine_transform_composer.sv
bench/testbench.sv
